@@ src/ftle_pkg.sv @@
// shared widths, payload types, constants and log table helper for the ftle block
`default_nettype none
package ftle_pkg;

  // position and derivative widths
  localparam int POS_W    = 32;
  localparam int DIFF_W   = POS_W + 1;
  localparam int FACT_W   = 32;
  localparam int PROD_W   = DIFF_W + FACT_W;
  localparam int MANT_W   = 30;
  localparam int LEN_W    = $clog2(PROD_W + 1);
  localparam int S_W      = $clog2(PROD_W - MANT_W + 1);

  // cauchy-green tensor and discriminant widths
  localparam int SQP_W    = 2 * MANT_W;
  localparam int AC_W     = SQP_W + 1;
  localparam int B_W      = SQP_W + 2;
  localparam int HALF_W   = B_W / 2;
  localparam int PP_W     = 2 * HALF_W;
  localparam int SQ_W     = 2 * B_W;
  localparam int RAD_W    = SQ_W + 2;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int REM_W    = ROOT_W + 2;
  localparam int ACS_W    = AC_W + 1;
  localparam int L_W      = ROOT_W + 1;
  localparam int E_W      = $clog2(L_W);

  // logarithm and output scaling widths
  localparam int INTERP_W = 16;
  localparam int TAB_W    = 33;
  localparam int EXP_W    = 9;
  localparam int EXP_OFS  = 2 * (POS_W + 12) + 1;
  localparam int YM_W     = EXP_W + 32;
  localparam int Y_W      = YM_W + 1;
  localparam int CFG_W    = 32;
  localparam int LOG_ADDR_BITS = 8;

  localparam logic [31:0]       HALF_LN2_Q32    = 32'h58B9_0BFC;
  localparam logic [CFG_W-1:0]  INV_HORIZON_RST = 32'h0001_0000;
  localparam logic [31:0]       FTLE_MIN        = 32'h8000_0000;
  localparam logic [31:0]       FTLE_MAX        = 32'h7FFF_FFFF;

  typedef struct packed {
    logic signed [POS_W-1:0]  east_x;
    logic signed [POS_W-1:0]  east_y;
    logic signed [POS_W-1:0]  west_x;
    logic signed [POS_W-1:0]  west_y;
    logic signed [POS_W-1:0]  north_x;
    logic signed [POS_W-1:0]  north_y;
    logic signed [POS_W-1:0]  south_x;
    logic signed [POS_W-1:0]  south_y;
    logic        [FACT_W-1:0] diff_scale;
  } in_t;

  typedef struct packed {
    logic signed [31:0] ftle_value;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic        [AC_W-1:0] a;
    logic        [AC_W-1:0] c;
    logic signed [B_W-1:0]  b;
    logic        [S_W-1:0]  s;
  } jac_t;

  typedef struct packed {
    logic [L_W-1:0] lsum;
    logic [S_W-1:0] s;
  } lsum_t;

  typedef struct packed {
    logic            zero;
    logic            neg;
    logic [YM_W-1:0] ymag;
  } log_t;

  // log2(1 + k/2^lb) in q0.32 by repeated squaring in q2.30
  function automatic logic [TAB_W-1:0] log_entry(input int unsigned k, input int unsigned lb);
    logic [63:0]      x;
    logic [TAB_W-1:0] res;
    res = '0;
    if (k >= (32'd1 << lb)) begin
      return 33'h1_0000_0000;
    end
    x = ((64'd1 << lb) + 64'(k)) << (30 - lb);
    for (int i = 31; i >= 0; i--) begin
      x = (x * x) >> 30;
      if (x >= 64'h8000_0000) begin
        res[i] = 1'b1;
        x = x >> 1;
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ src/ftle_jac.sv @@
// jacobian by central differences, block scaling and cauchy-green entries a, b, c
`default_nettype none
module ftle_jac
  import ftle_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_valid,
  input  in_t  in_data,
  output logic out_valid,
  output jac_t out_data
);

  localparam int NST = 7;

  logic [NST-1:0] v_r;

  logic signed [DIFF_W-1:0] d_r   [4];
  logic signed [DIFF_W-1:0] d_nxt [4];
  logic [FACT_W-1:0]        f1_r, f2_r;
  logic [DIFF_W-1:0]        ad_r  [4];
  logic [DIFF_W-1:0]        ad_nxt[4];
  logic [3:0]               ng2_r, ng3_r, ng4_r, ng5_r;
  logic [PROD_W-1:0]        m_r   [4];
  logic [PROD_W-1:0]        m4_r  [4];
  logic [PROD_W-1:0]        mor;
  logic [LEN_W-1:0]         nlen;
  logic [S_W-1:0]           s4_r, s4_nxt, s5_r, s6_r;
  logic [MANT_W-1:0]        j_r   [4];
  logic [SQP_W-1:0]         p_r   [6];
  logic                     ng01_r, ng23_r;
  logic signed [B_W-1:0]    t01, t23;
  jac_t                     out_r, out_nxt;

  // valid bits follow the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_valid};
    end
  end

  // stage 1 differences of sign-extended positions
  always_comb begin
    d_nxt[0] = $signed({in_data.east_x[POS_W-1], in_data.east_x})
             - $signed({in_data.west_x[POS_W-1], in_data.west_x});
    d_nxt[1] = $signed({in_data.north_x[POS_W-1], in_data.north_x})
             - $signed({in_data.south_x[POS_W-1], in_data.south_x});
    d_nxt[2] = $signed({in_data.east_y[POS_W-1], in_data.east_y})
             - $signed({in_data.west_y[POS_W-1], in_data.west_y});
    d_nxt[3] = $signed({in_data.north_y[POS_W-1], in_data.north_y})
             - $signed({in_data.south_y[POS_W-1], in_data.south_y});
  end

  // stage 2 magnitudes and signs
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ad_nxt[i] = d_r[i][DIFF_W-1] ? DIFF_W'(-d_r[i]) : DIFF_W'(d_r[i]);
    end
  end

  // stage 4 bit length of the largest product and block shift
  always_comb begin
    mor  = m_r[0] | m_r[1] | m_r[2] | m_r[3];
    nlen = '0;
    for (int i = 0; i < PROD_W; i++) begin
      if (mor[i]) nlen = LEN_W'(i + 1);
    end
    s4_nxt = (nlen > LEN_W'(MANT_W)) ? S_W'(nlen - LEN_W'(MANT_W)) : '0;
  end

  // stage 7 tensor entries
  always_comb begin
    t01 = $signed({2'b00, p_r[4]});
    t23 = $signed({2'b00, p_r[5]});
    out_nxt.a = AC_W'(p_r[0]) + AC_W'(p_r[2]);
    out_nxt.c = AC_W'(p_r[1]) + AC_W'(p_r[3]);
    out_nxt.b = (ng01_r ? -t01 : t01) + (ng23_r ? -t23 : t23);
    out_nxt.s = s6_r;
  end

  // pipeline payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        d_r[i]  <= d_nxt[i];
        ad_r[i] <= ad_nxt[i];
        m_r[i]  <= PROD_W'(ad_r[i]) * PROD_W'(f2_r);
        m4_r[i] <= m_r[i];
        j_r[i]  <= MANT_W'(m4_r[i] >> s4_r);
      end
      f1_r  <= in_data.diff_scale;
      f2_r  <= f1_r;
      ng2_r <= {d_r[3][DIFF_W-1], d_r[2][DIFF_W-1], d_r[1][DIFF_W-1], d_r[0][DIFF_W-1]};
      ng3_r <= ng2_r;
      ng4_r <= ng3_r;
      ng5_r <= ng4_r;
      s4_r  <= s4_nxt;
      s5_r  <= s4_r;
      s6_r  <= s5_r;
      p_r[0] <= SQP_W'(j_r[0]) * SQP_W'(j_r[0]);
      p_r[1] <= SQP_W'(j_r[1]) * SQP_W'(j_r[1]);
      p_r[2] <= SQP_W'(j_r[2]) * SQP_W'(j_r[2]);
      p_r[3] <= SQP_W'(j_r[3]) * SQP_W'(j_r[3]);
      p_r[4] <= SQP_W'(j_r[0]) * SQP_W'(j_r[1]);
      p_r[5] <= SQP_W'(j_r[2]) * SQP_W'(j_r[3]);
      ng01_r <= ng5_r[0] ^ ng5_r[1];
      ng23_r <= ng5_r[2] ^ ng5_r[3];
      out_r  <= out_nxt;
    end
  end

  assign out_valid = v_r[NST-1];
  assign out_data  = out_r;

endmodule
`default_nettype wire

@@ src/ftle_sqrt.sv @@
// discriminant squares and pipelined floor square root, giving a + c + sqrt
`default_nettype none
module ftle_sqrt
  import ftle_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_valid,
  input  jac_t  in_data,
  output logic  out_valid,
  output lsum_t out_data
);

  localparam int NST = 4 + ROOT_W + 1;

  logic [NST-1:0] v_r;

  logic signed [AC_W:0]  amc;
  logic signed [B_W-1:0] babs;
  logic [AC_W-1:0]       am_r, am_nxt;
  logic [B_W-1:0]        bm_r, bm_nxt;
  logic [ACS_W-1:0]      acs1_r, acs2_r, acs3_r;
  logic [S_W-1:0]        s1_r, s2_r, s3_r;
  logic [B_W-1:0]        xa, xb;
  logic [PP_W-1:0]       pp_r [6];
  logic [SQ_W-1:0]       sq_r [2];

  logic [RAD_W-1:0]      rad_r  [ROOT_W+1];
  logic [ACS_W-1:0]      acs_r  [ROOT_W+1];
  logic [S_W-1:0]        s_r    [ROOT_W+1];
  logic [REM_W-1:0]      rem_r  [1:ROOT_W];
  logic [ROOT_W-1:0]     root_r [1:ROOT_W];
  lsum_t                 out_r;

  // valid bits follow the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_valid};
    end
  end

  // stage 1 |a - c| and 2|b|
  always_comb begin
    amc    = $signed({1'b0, in_data.a}) - $signed({1'b0, in_data.c});
    am_nxt = amc[AC_W] ? AC_W'(-amc) : AC_W'(amc);
    babs   = in_data.b[B_W-1] ? -in_data.b : in_data.b;
    bm_nxt = {babs[B_W-2:0], 1'b0};
  end

  assign xa = {1'b0, am_r};
  assign xb = bm_r;

  // stages 1 to 4: split squares, then sum to the discriminant
  always_ff @(posedge clk) begin
    if (en) begin
      am_r   <= am_nxt;
      bm_r   <= bm_nxt;
      acs1_r <= ACS_W'(in_data.a) + ACS_W'(in_data.c);
      s1_r   <= in_data.s;
      pp_r[0] <= PP_W'(xa[B_W-1:HALF_W]) * PP_W'(xa[B_W-1:HALF_W]);
      pp_r[1] <= PP_W'(xa[B_W-1:HALF_W]) * PP_W'(xa[HALF_W-1:0]);
      pp_r[2] <= PP_W'(xa[HALF_W-1:0]) * PP_W'(xa[HALF_W-1:0]);
      pp_r[3] <= PP_W'(xb[B_W-1:HALF_W]) * PP_W'(xb[B_W-1:HALF_W]);
      pp_r[4] <= PP_W'(xb[B_W-1:HALF_W]) * PP_W'(xb[HALF_W-1:0]);
      pp_r[5] <= PP_W'(xb[HALF_W-1:0]) * PP_W'(xb[HALF_W-1:0]);
      acs2_r <= acs1_r;
      s2_r   <= s1_r;
      sq_r[0] <= (SQ_W'(pp_r[0]) << (2 * HALF_W)) + (SQ_W'(pp_r[1]) << (HALF_W + 1))
               + SQ_W'(pp_r[2]);
      sq_r[1] <= (SQ_W'(pp_r[3]) << (2 * HALF_W)) + (SQ_W'(pp_r[4]) << (HALF_W + 1))
               + SQ_W'(pp_r[5]);
      acs3_r <= acs2_r;
      s3_r   <= s2_r;
      rad_r[0] <= RAD_W'(sq_r[0]) + RAD_W'(sq_r[1]);
      acs_r[0] <= acs3_r;
      s_r[0]   <= s3_r;
    end
  end

  // one root bit per stage, restoring method
  for (genvar g = 0; g < ROOT_W; g++) begin : g_sq
    logic [REM_W-1:0]  rem_in, rem_nxt;
    logic [ROOT_W-1:0] root_in, root_nxt;
    logic [REM_W+1:0]  cur, trial;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[g];
      assign root_in = root_r[g];
    end

    always_comb begin
      cur   = {rem_in, rad_r[g][RAD_W-1 -: 2]};
      trial = (REM_W + 2)'({root_in, 2'b01});
      if (cur >= trial) begin
        rem_nxt  = REM_W'(cur - trial);
        root_nxt = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = REM_W'(cur);
        root_nxt = {root_in[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g+1]  <= rem_nxt;
        root_r[g+1] <= root_nxt;
        rad_r[g+1]  <= rad_r[g] << 2;
        acs_r[g+1]  <= acs_r[g];
        s_r[g+1]    <= s_r[g];
      end
    end
  end

  // largest eigenvalue numerator
  always_ff @(posedge clk) begin
    if (en) begin
      out_r.lsum <= L_W'(acs_r[ROOT_W]) + L_W'(root_r[ROOT_W]);
      out_r.s    <= s_r[ROOT_W];
    end
  end

  assign out_valid = v_r[NST-1];
  assign out_data  = out_r;

endmodule
`default_nettype wire

@@ src/ftle_log.sv @@
// log2 of the eigenvalue by leading one, table lookup and linear interpolation
`default_nettype none
module ftle_log
  import ftle_pkg::*;
#(
  parameter int LB = LOG_ADDR_BITS
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_valid,
  input  lsum_t in_data,
  output logic  out_valid,
  output log_t  out_data
);

  localparam int NST   = 5;
  localparam int FB    = LB + INTERP_W;
  localparam int TAB_N = 1 << LB;

  typedef logic [TAB_W-1:0] tab_t [TAB_N];

  function automatic tab_t build_tab();
    tab_t t;
    for (int i = 0; i < TAB_N; i++) begin
      t[i] = log_entry(32'(i), 32'(LB));
    end
    return t;
  endfunction

  localparam tab_t LOG_TAB = build_tab();

  logic [NST-1:0] v_r;

  logic [L_W-1:0]      l1_r;
  logic [E_W-1:0]      e_nxt, e1_r, e2_r;
  logic [S_W-1:0]      s1_r, s2_r;
  logic                z1_r, z2_r, z3_r, z4_r;
  logic [L_W-1:0]      norm;
  logic [FB-1:0]       f;
  logic [LB-1:0]       k2_r;
  logic [INTERP_W-1:0] r2_r, r3_r;
  logic [LB-1:0]       k0, k1;
  logic [TAB_W-1:0]    t0_r, t1_r, dt, frac_nxt, frac_r;
  logic [TAB_W+INTERP_W-1:0] ip;
  logic [EXP_W-1:0]    expo3_r, expo4_r;
  logic [Y_W-1:0]      y;
  log_t                out_r, out_nxt;

  // valid bits follow the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_valid};
    end
  end

  // stage 1 leading one position
  always_comb begin
    e_nxt = '0;
    for (int i = 0; i < L_W; i++) begin
      if (in_data.lsum[i]) e_nxt = E_W'(i);
    end
  end

  // stage 2 normalize and pick table address and interpolation bits
  always_comb begin
    norm = l1_r << (E_W'(L_W - 1) - e1_r);
    f    = norm[L_W-2 -: FB];
  end

  // stage 3 table neighbors; past the last entry the value is log2(2) = 1
  assign k0 = k2_r;
  assign k1 = k2_r + 1'b1;

  // stage 4 interpolation
  always_comb begin
    dt       = t1_r - t0_r;
    ip       = (TAB_W + INTERP_W)'(dt) * (TAB_W + INTERP_W)'(r3_r);
    frac_nxt = t0_r + TAB_W'(ip >> INTERP_W);
  end

  // stage 5 signed log2 and its magnitude
  always_comb begin
    y = {expo4_r[EXP_W-1], expo4_r, 32'h0} + {{(Y_W - TAB_W){1'b0}}, frac_r};
    out_nxt.zero = z4_r;
    out_nxt.neg  = y[Y_W-1];
    out_nxt.ymag = y[Y_W-1] ? YM_W'(-y) : YM_W'(y);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l1_r    <= in_data.lsum;
      e1_r    <= e_nxt;
      s1_r    <= in_data.s;
      z1_r    <= (in_data.lsum == '0);
      k2_r    <= f[FB-1:INTERP_W];
      r2_r    <= f[INTERP_W-1:0];
      e2_r    <= e1_r;
      s2_r    <= s1_r;
      z2_r    <= z1_r;
      t0_r    <= LOG_TAB[k0];
      t1_r    <= (&k2_r) ? {1'b1, 32'h0} : LOG_TAB[k1];
      r3_r    <= r2_r;
      expo3_r <= EXP_W'(e2_r) + EXP_W'({s2_r, 1'b0}) - EXP_W'(EXP_OFS);
      z3_r    <= z2_r;
      frac_r  <= frac_nxt;
      expo4_r <= expo3_r;
      z4_r    <= z3_r;
      out_r   <= out_nxt;
    end
  end

  assign out_valid = v_r[NST-1];
  assign out_data  = out_r;

endmodule
`default_nettype wire

@@ src/ftle_out.sv @@
// ln(sqrt) scaling, horizon scaling, saturation and the result register
`default_nettype none
module ftle_out
  import ftle_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [CFG_W-1:0] inv_horizon,
  input  logic             in_valid,
  input  log_t             in_data,
  output logic             out_valid,
  output out_t             out_data
);

  localparam int NST = 5;

  logic [NST-1:0] v_r;

  logic [63:0]     plo_r, qlo_r;
  logic [YM_W-1:0] phi_r, qhi_r, z_r, mag_r;
  logic [3:0]      zero_r, neg_r;
  out_t            out_r, out_nxt;

  // valid bits follow the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_valid};
    end
  end

  // saturate and apply the sign
  always_comb begin
    out_nxt.ftle_value = mag_r[31:0];
    out_nxt.saturated  = 1'b0;
    if (zero_r[3]) begin
      out_nxt.ftle_value = FTLE_MIN;
      out_nxt.saturated  = 1'b1;
    end else if (neg_r[3]) begin
      if (mag_r > YM_W'(FTLE_MIN)) begin
        out_nxt.ftle_value = FTLE_MIN;
        out_nxt.saturated  = 1'b1;
      end else begin
        out_nxt.ftle_value = -mag_r[31:0];
      end
    end else if (mag_r > YM_W'(FTLE_MAX)) begin
      out_nxt.ftle_value = FTLE_MAX;
      out_nxt.saturated  = 1'b1;
    end
  end

  // split 32-bit multiplies with a register after each
  always_ff @(posedge clk) begin
    if (en) begin
      plo_r  <= 64'(in_data.ymag[31:0]) * 64'(HALF_LN2_Q32);
      phi_r  <= YM_W'(in_data.ymag[YM_W-1:32]) * YM_W'(HALF_LN2_Q32);
      z_r    <= phi_r + YM_W'(plo_r[63:32]);
      qlo_r  <= 64'(z_r[31:0]) * 64'(inv_horizon);
      qhi_r  <= YM_W'(z_r[YM_W-1:32]) * YM_W'(inv_horizon);
      mag_r  <= qhi_r + YM_W'(qlo_r[63:32]);
      zero_r <= {zero_r[2:0], in_data.zero};
      neg_r  <= {neg_r[2:0], in_data.neg};
      out_r  <= out_nxt;
    end
  end

  assign out_valid = v_r[NST-1];
  assign out_data  = out_r;

endmodule
`default_nettype wire

@@ src/ftle_from_flow_map_stencil.sv @@
// ftle stencil top: one grid point in, one signed q16.16 exponent out
// throughput one point per cycle unless stalled; the 63-stage root pipeline sets the depth
// a stalled result beat freezes every stage, so input stall follows output stall
// synchronous reset clears all valid bits and sets inv_horizon to 1.0; no clearing pass
`default_nettype none
module ftle_from_flow_map_stencil
  import ftle_pkg::*;
#(
  parameter int LOG_TABLE_ADDR_BITS = LOG_ADDR_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_t             out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  logic             en;
  logic [CFG_W-1:0] inv_horizon_r;
  logic             jac_v, sq_v, log_v;
  jac_t             jac_d;
  lsum_t            sq_d;
  log_t             log_d;

  // whole pipeline advances unless the result beat is held
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_horizon_r <= INV_HORIZON_RST;
    end else if (cfg_valid && cfg_ready) begin
      inv_horizon_r <= cfg_data;
    end
  end

  ftle_jac u_jac (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (jac_v),
    .out_data  (jac_d)
  );

  ftle_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (jac_v),
    .in_data   (jac_d),
    .out_valid (sq_v),
    .out_data  (sq_d)
  );

  ftle_log #(
    .LB (LOG_TABLE_ADDR_BITS)
  ) u_log (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_v),
    .in_data   (sq_d),
    .out_valid (log_v),
    .out_data  (log_d)
  );

  ftle_out u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .inv_horizon (inv_horizon_r),
    .in_valid    (log_v),
    .in_data     (log_d),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

`ifndef SYNTH
  // a config beat lands in the register
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |=> (inv_horizon_r == $past(cfg_data)))
    else $error("inv_horizon not updated by config beat");

  // input back pressure only comes from a held result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled without a held result");

  // a flagged result is one of the two clamp values
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.saturated) |->
      (out_data.ftle_value == FTLE_MIN || out_data.ftle_value == FTLE_MAX))
    else $error("saturated result not clamped");
`endif

endmodule
`default_nettype wire
